// ===== rtl/core/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; define ASSERT_OFF to compile them away.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/sh3_pkg.sv =====
// -----------------------------------------------------------------------------
// sh3_pkg
// Widths, register codes and shared types of the 3x3 sharpen stencil.
// -----------------------------------------------------------------------------
package sh3_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int ROW_W      = 12;
	localparam int IDX_W      = 13;
	localparam int LEN_W      = 14;
	localparam int WPX_W      = 12;
	localparam int HROW_W     = 13;
	localparam int CHN_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// hard limits on line length and frame height
	localparam int LINE_CAP = 8192;
	localparam int ROW_CAP  = 4096;

	// register reset values
	localparam int WPX_RST  = 640;
	localparam int HROW_RST = 480;
	localparam int CHN_RST  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PIXELS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_ROWS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	// position of the sample about to be accepted
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [ROW_W-1:0] row;
		logic [IDX_W-1:0] idx_right;
		logic [IDX_W-1:0] idx_left;
		logic             has_prev;  // row above gets its result now
		logic             inner;     // that result is an interior sample
		logic             last_row;
		logic             last;
	} pos_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic [ROW_W-1:0]    row;
		logic [IDX_W-1:0]    index;
		logic                frame_end;
	} res_t;

endpackage

// ===== rtl/core/sh3_in_if.sv =====
// -----------------------------------------------------------------------------
// sh3_in_if
// Input sample channel: valid/ready with one 8-bit sample per beat.
// -----------------------------------------------------------------------------
interface sh3_in_if;
	import sh3_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/core/sh3_out_if.sv =====
// -----------------------------------------------------------------------------
// sh3_out_if
// Result channel: valid/ready with value, position and end-of-frame flag.
// -----------------------------------------------------------------------------
interface sh3_out_if;
	import sh3_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] value;
	logic [ROW_W-1:0]    out_row;
	logic [IDX_W-1:0]    out_index;
	logic                frame_end;

	modport source (output valid, output value, output out_row, output out_index,
		output frame_end, input ready);
	modport sink   (input valid, input value, input out_row, input out_index,
		input frame_end, output ready);
endinterface

// ===== rtl/core/sharpen_3x3_stencil.sv =====
// -----------------------------------------------------------------------------
// sharpen_3x3_stencil
// 3x3 Laplacian sharpen over an interleaved raster stream with two line stores.
//
//   channel  dir  beat                                   notes
//   din      in   sample                                 raster order, channels interleaved
//   dout     out  value, out_row, out_index, frame_end   results for the row above and the last row
//   cfg      in   cfg_we, cfg_index, cfg_data            width, height, channel count
//
// One sample per cycle unless the result port or a configuration write holds
// din; data passes the s1 registers, then p0_q/p1_q. Each last-row sample
// below the first row gives two results, so there the single result port
// holds back din. Line store reads are registered at accept; a line_two_above
// write lands in the cycle after accept and is forwarded. After a
// configuration write din stalls while sizes settle and the position folds.
// Reset clears counters and valids; line stores stay undefined until written.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module sharpen_3x3_stencil #(
	parameter int MAX_LINE_SAMPLES = 8192
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sh3_in_if.sink                         din,
	sh3_out_if.source                      dout,
	input  logic                           cfg_we,
	input  logic [sh3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sh3_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sh3_pkg::*;

	localparam int ADDR_W  = $clog2(MAX_LINE_SAMPLES);
	localparam int LEN_CAP = (MAX_LINE_SAMPLES < LINE_CAP) ? MAX_LINE_SAMPLES : LINE_CAP;

	pos_t pos;
	logic cfg_idle;
	logic in_take;
	logic out_take;

	logic [ADDR_W-1:0] addr_i;
	logic [ADDR_W-1:0] addr_right;
	logic [ADDR_W-1:0] addr_left;

	logic [SAMPLE_W-1:0] ctr_rd;
	logic [SAMPLE_W-1:0] rgt_rd;
	logic [SAMPLE_W-1:0] up_rd;
	logic [SAMPLE_W-1:0] lft_rd;

	logic              pw_v_q;
	logic [ADDR_W-1:0] pw_addr_q;

	logic                valid_s1;
	pos_t                pos_s1;
	logic [SAMPLE_W-1:0] down_s1;
	logic                fwd_up_s1;
	logic                fwd_lf_s1;
	logic [SAMPLE_W-1:0] fwd_data_s1;

	logic [SAMPLE_W-1:0] up_val;
	logic [SAMPLE_W-1:0] lft_val;
	logic [SAMPLE_W-1:0] kern_val;
	res_t                res0;
	res_t                res1;
	logic                s1_has;
	logic                s2_free;
	logic                adv_s1;
	logic                load_s2;

	logic v0_q;
	logic v1_q;
	res_t p0_q;
	res_t p1_q;
	res_t head;

	sh3_pos #(.LEN_CAP(LEN_CAP)) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_take),
		.in_valid  (din.valid),
		.pos       (pos),
		.idle      (cfg_idle)
	);

	assign in_take    = din.valid && din.ready;
	assign out_take   = dout.valid && dout.ready;
	assign addr_i     = ADDR_W'(pos.idx);
	assign addr_right = ADDR_W'(pos.idx_right);
	assign addr_left  = ADDR_W'(pos.idx_left);

	// line_above: new sample goes in at accept, reads see the previous row
	sh3_ram #(.DEPTH(MAX_LINE_SAMPLES)) u_line_above (
		.clk    (clk),
		.we     (in_take),
		.waddr  (addr_i),
		.wdata  (din.sample),
		.re     (in_take),
		.raddr0 (addr_i),
		.raddr1 (addr_right),
		.rdata0 (ctr_rd),
		.rdata1 (rgt_rd)
	);

	// line_two_above: rotated copy of line_above, written in the cycle after accept
	sh3_ram #(.DEPTH(MAX_LINE_SAMPLES)) u_line_two_above (
		.clk    (clk),
		.we     (pw_v_q),
		.waddr  (pw_addr_q),
		.wdata  (ctr_rd),
		.re     (in_take),
		.raddr0 (addr_i),
		.raddr1 (addr_left),
		.rdata0 (up_rd),
		.rdata1 (lft_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_v_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			pw_v_q <= in_take;
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pw_addr_q   <= addr_i;
			pos_s1      <= pos;
			down_s1     <= din.sample;
			// the pending rotate write lands on this edge; take its data directly
			fwd_up_s1   <= pw_v_q && (pw_addr_q == addr_i);
			fwd_lf_s1   <= pw_v_q && (pw_addr_q == addr_left);
			fwd_data_s1 <= ctr_rd;
		end
	end

	assign up_val  = fwd_up_s1 ? fwd_data_s1 : up_rd;
	assign lft_val = fwd_lf_s1 ? fwd_data_s1 : lft_rd;

	sh3_kern u_kern (
		.inner  (pos_s1.inner),
		.center (ctr_rd),
		.left   (lft_val),
		.right  (rgt_rd),
		.up     (up_val),
		.down   (down_s1),
		.value  (kern_val)
	);

	always_comb begin
		res0.value     = kern_val;
		res0.row       = pos_s1.row - ROW_W'(1);
		res0.index     = pos_s1.idx;
		res0.frame_end = 1'b0;
		res1.value     = '0;
		res1.row       = pos_s1.row;
		res1.index     = pos_s1.idx;
		res1.frame_end = pos_s1.last;
	end

	assign s1_has  = pos_s1.has_prev || pos_s1.last_row;
	assign s2_free = !(v0_q || v1_q) || (out_take && !(v0_q && v1_q));
	assign adv_s1  = valid_s1 && (!s1_has || s2_free);
	assign load_s2 = adv_s1 && s1_has;

	assign din.ready = cfg_idle && (!valid_s1 || adv_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (load_s2) begin
			v0_q <= pos_s1.has_prev;
			v1_q <= pos_s1.last_row;
		end else if (out_take) begin
			// drop the beat just taken, upper row first
			if (v0_q) begin
				v0_q <= 1'b0;
			end else begin
				v1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			p0_q <= res0;
			p1_q <= res1;
		end
	end

	assign head           = v0_q ? p0_q : p1_q;
	assign dout.valid     = v0_q || v1_q;
	assign dout.value     = head.value;
	assign dout.out_row   = head.row;
	assign dout.out_index = head.index;
	assign dout.frame_end = head.frame_end;

	`ASSERT_IMPLY(a_pair_pos, clk, arst_n, v0_q && v1_q, (p1_q.row == p0_q.row + 1'b1) && (p1_q.index == p0_q.index))
	`ASSERT_IMPLY(a_end_zero, clk, arst_n, dout.valid && dout.frame_end, dout.value == '0)
	`ASSERT_NEXT(a_cfg_settle, clk, arst_n, cfg_we, !(din.valid && din.ready))
endmodule

// ===== rtl/core/sh3_ram.sv =====
// -----------------------------------------------------------------------------
// sh3_ram
// Line store: one write port, two registered read ports, read-old on collision.
// -----------------------------------------------------------------------------
module sh3_ram #(
	parameter int DEPTH = 8192,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [ADDR_W-1:0]            waddr,
	input  logic [sh3_pkg::SAMPLE_W-1:0] wdata,
	input  logic                         re,
	input  logic [ADDR_W-1:0]            raddr0,
	input  logic [ADDR_W-1:0]            raddr1,
	output logic [sh3_pkg::SAMPLE_W-1:0] rdata0,
	output logic [sh3_pkg::SAMPLE_W-1:0] rdata1
);
	import sh3_pkg::*;

	logic [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end
endmodule

// ===== rtl/core/sh3_pos.sv =====
// -----------------------------------------------------------------------------
// sh3_pos
// Configuration registers, effective frame sizes and the raster position.
// -----------------------------------------------------------------------------
module sh3_pos #(
	parameter int LEN_CAP = 8192
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sh3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sh3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           advance,
	input  logic                           in_valid,
	output sh3_pkg::pos_t                  pos,
	output logic                           idle
);
	import sh3_pkg::*;

	localparam int LEN_PROD = WPX_RST * CHN_RST;
	localparam int LEN_RST  = (LEN_PROD > LEN_CAP) ? LEN_CAP : LEN_PROD;
	localparam logic [1:0] SETTLE = 2'd2;

	logic [WPX_W-1:0]  wpx_q;
	logic [HROW_W-1:0] hrow_q;
	logic [CHN_W-1:0]  chn_q;
	logic [LEN_W-1:0]  len_q;
	logic [HROW_W-1:0] h_q;
	logic [CHN_W-1:0]  c_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ROW_W-1:0]  row_q;
	logic [1:0]        wait_q;
	logic              fold_q;

	logic [WPX_W-1:0]  w_eff;
	logic [CHN_W-1:0]  c_eff;
	logic [HROW_W-1:0] h_eff;
	logic [LEN_W:0]    prod;
	logic [LEN_W-1:0]  len_n;
	logic [HROW_W-1:0] h_n;

	logic [LEN_W-1:0]  i1;
	logic [HROW_W-1:0] r1;
	logic              wrap;
	logic              idx_ge;
	logic [HROW_W-1:0] row_t;
	logic [LEN_W-1:0]  i_right;
	logic              fold_now;

	always_comb begin
		w_eff = (wpx_q == '0) ? WPX_W'(1) : wpx_q;
		c_eff = (chn_q == '0) ? CHN_W'(1) : chn_q;
		h_eff = (hrow_q == '0) ? HROW_W'(1) : hrow_q;
		prod  = (LEN_W + 1)'(w_eff) * (LEN_W + 1)'(c_eff);
		len_n = (prod > (LEN_W + 1)'(LEN_CAP)) ? LEN_W'(LEN_CAP) : prod[LEN_W-1:0];
		h_n   = (h_eff > HROW_W'(ROW_CAP)) ? HROW_W'(ROW_CAP) : h_eff;
	end

	always_comb begin
		i1      = LEN_W'(idx_q) + LEN_W'(1);
		r1      = HROW_W'(row_q) + HROW_W'(1);
		wrap    = (i1 >= len_q);
		idx_ge  = (LEN_W'(idx_q) >= len_q);
		row_t   = idx_ge ? r1 : HROW_W'(row_q);
		i_right = LEN_W'(idx_q) + LEN_W'(c_q);
	end

	always_comb begin
		pos.idx       = idx_q;
		pos.row       = row_q;
		pos.idx_right = i_right[IDX_W-1:0];
		pos.idx_left  = idx_q - IDX_W'(c_q);
		pos.has_prev  = (row_q != '0);
		pos.inner     = (row_q >= ROW_W'(2)) && (idx_q >= IDX_W'(c_q)) && (i_right < len_q);
		pos.last_row  = (r1 == h_q);
		pos.last      = (r1 == h_q) && (i1 == len_q);
	end

	assign idle     = (wait_q == '0) && !fold_q;
	// fold only when a beat waits, so every write before it counts
	assign fold_now = fold_q && (wait_q != SETTLE) && !cfg_we && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpx_q  <= WPX_W'(WPX_RST);
			hrow_q <= HROW_W'(HROW_RST);
			chn_q  <= CHN_W'(CHN_RST);
			len_q  <= LEN_W'(LEN_RST);
			h_q    <= HROW_W'(HROW_RST);
			c_q    <= CHN_W'(CHN_RST);
			idx_q  <= '0;
			row_q  <= '0;
			wait_q <= '0;
			fold_q <= 1'b0;
		end else begin
			len_q <= len_n;
			h_q   <= h_n;
			c_q   <= c_eff;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH_PIXELS:  wpx_q  <= cfg_data[WPX_W-1:0];
					REG_HEIGHT_ROWS:   hrow_q <= cfg_data[HROW_W-1:0];
					REG_CHANNEL_COUNT: chn_q  <= cfg_data[CHN_W-1:0];
					default: ;
				endcase
				wait_q <= SETTLE;
				fold_q <= 1'b1;
			end else if (wait_q != '0) begin
				wait_q <= wait_q - 2'd1;
			end
			// fold the position back into the new frame once sizes have settled
			if (fold_now) begin
				if (idx_ge) begin
					idx_q <= '0;
				end
				row_q  <= (row_t >= h_q) ? '0 : row_t[ROW_W-1:0];
				fold_q <= 1'b0;
			end else if (advance) begin
				if (wrap) begin
					idx_q <= '0;
					row_q <= (r1 >= h_q) ? '0 : r1[ROW_W-1:0];
				end else begin
					idx_q <= i1[IDX_W-1:0];
				end
			end
		end
	end
endmodule

// ===== rtl/core/sh3_kern.sv =====
// -----------------------------------------------------------------------------
// sh3_kern
// Laplacian sharpen kernel: 5*center minus four neighbors, clamped to a byte; zero off the interior.
// -----------------------------------------------------------------------------
module sh3_kern (
	input  logic                         inner,
	input  logic [sh3_pkg::SAMPLE_W-1:0] center,
	input  logic [sh3_pkg::SAMPLE_W-1:0] left,
	input  logic [sh3_pkg::SAMPLE_W-1:0] right,
	input  logic [sh3_pkg::SAMPLE_W-1:0] up,
	input  logic [sh3_pkg::SAMPLE_W-1:0] down,
	output logic [sh3_pkg::SAMPLE_W-1:0] value
);
	import sh3_pkg::*;

	localparam int ACC_W = SAMPLE_W + 4;

	logic [SAMPLE_W+2:0]     five;
	logic [SAMPLE_W+1:0]     ring;
	logic signed [ACC_W-1:0] acc;

	always_comb begin
		five = {1'b0, center, 2'b00} + (SAMPLE_W + 3)'(center);
		ring = (SAMPLE_W + 2)'(left) + (SAMPLE_W + 2)'(right)
			+ (SAMPLE_W + 2)'(up) + (SAMPLE_W + 2)'(down);
		acc  = $signed(ACC_W'(five)) - $signed(ACC_W'(ring));
		if (!inner || acc < 0) begin
			value = '0;
		end else if (acc > $signed(ACC_W'(255))) begin
			value = '1;
		end else begin
			value = acc[SAMPLE_W-1:0];
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
// -----------------------------------------------------------------------------
// testbench
// Streams raster frames through the 3x3 sharpen stencil and predicts every
// result from an internal copy of both line stores and the position counters.
// The predicted results are compared in order with the results the block
// returns, under random gaps and stalls on both channels, long output holds,
// a size change inside a frame, single-row frames and partial frames at the
// largest sizes.
// -----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sh3_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int QUIET_LIMIT    = 3000;
	localparam int RANDOM_SAMPLES = 700;
	localparam int LARGE_SAMPLES  = 100;
	localparam int REPORT_LIMIT   = 50;
	localparam int IDLE_PCT       = 18;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	sh3_in_if  din_if ();
	sh3_out_if dout_if ();

	sharpen_3x3_stencil dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din_if),
		.dout     (dout_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// mirror of the block's registers, line stores and raster position
	logic [WPX_W-1:0]    cur_width    = WPX_W'(WPX_RST);
	logic [HROW_W-1:0]   cur_height   = HROW_W'(HROW_RST);
	logic [CHN_W-1:0]    cur_channels = CHN_W'(CHN_RST);
	bit   [SAMPLE_W-1:0] prev_line      [LINE_CAP];
	bit   [SAMPLE_W-1:0] prev_prev_line [LINE_CAP];
	int unsigned         row_pos = 0;
	int unsigned         idx_pos = 0;

	res_t sharpened_due[$];

	int gap_pct       = IDLE_PCT;
	int stall_pct     = IDLE_PCT;
	int fail_count    = 0;
	int samples_sent  = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the raster position by one sample and queue the results it releases.
	function automatic void sharpen_step(input logic [SAMPLE_W-1:0] s);
		int unsigned chans, wpx, len, rows, r, i;
		int          acc;
		logic        last_row;
		res_t        res;
		chans = (cur_channels == 0) ? 1 : cur_channels;
		wpx   = (cur_width == 0) ? 1 : cur_width;
		rows  = (cur_height == 0) ? 1 : cur_height;
		len   = wpx * chans;
		if (len > LINE_CAP) len = LINE_CAP;
		if (rows > ROW_CAP) rows = ROW_CAP;
		// sizes may have shrunk under the current position
		if (idx_pos >= len) begin
			idx_pos = 0;
			row_pos++;
		end
		if (row_pos >= rows) row_pos = 0;
		r = row_pos;
		i = idx_pos;
		last_row = (r + 1 == rows);
		if (r >= 1) begin
			acc = 0;
			if (r >= 2 && i >= chans && i + chans < len) begin
				// left neighbor of the row above has already rotated down
				acc = 5 * int'(prev_line[i]) - int'(prev_prev_line[i - chans])
					- int'(prev_line[i + chans]) - int'(prev_prev_line[i]) - int'(s);
				if (acc < 0) acc = 0;
				else if (acc > 255) acc = 255;
			end
			res.value     = SAMPLE_W'(acc);
			res.row       = ROW_W'(r - 1);
			res.index     = IDX_W'(i);
			res.frame_end = 1'b0;
			sharpened_due.push_back(res);
		end
		if (last_row) begin
			res.value     = '0;
			res.row       = ROW_W'(r);
			res.index     = IDX_W'(i);
			res.frame_end = (i + 1 == len);
			sharpened_due.push_back(res);
		end
		prev_prev_line[i] = prev_line[i];
		prev_line[i]      = s;
		idx_pos = i + 1;
		if (idx_pos >= len) begin
			idx_pos = 0;
			row_pos = r + 1;
			if (row_pos >= rows) row_pos = 0;
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(255));
		endcase
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < gap_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid  <= 1'b1;
		din_if.sample <= s;
		do @(posedge clk); while (!din_if.ready);
		sharpen_step(s);
		samples_sent++;
	endtask

	// Drop valid, let every queued result come back, then let the pipe settle.
	task automatic wait_idle();
		din_if.valid <= 1'b0;
		while (sharpened_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last register.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(data);
		@(posedge clk);
		case (idx)
			REG_WIDTH_PIXELS:  cur_width    = WPX_W'(data);
			REG_HEIGHT_ROWS:   cur_height   = HROW_W'(data);
			REG_CHANNEL_COUNT: cur_channels = CHN_W'(data);
			default: ;
		endcase
	endtask

	task automatic set_frame(input int unsigned wpx, input int unsigned rows,
		input int unsigned chans);
		wait_idle();
		write_reg(REG_WIDTH_PIXELS, wpx);
		write_reg(REG_HEIGHT_ROWS, rows);
		write_reg(REG_CHANNEL_COUNT, chans);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input int unsigned wpx, input int unsigned rows,
		input int unsigned chans);
		set_frame(wpx, rows, chans);
		repeat (wpx * rows * chans) send_sample(random_sample());
	endtask

	// 4x3 gray frame: one interior sample clips high, its neighbor clips low.
	task automatic test_directed_saturation();
		logic [SAMPLE_W-1:0] pattern [12];
		pattern = '{8'd17, 8'd0, 8'd255, 8'd200,
			8'd90, 8'd255, 8'd0, 8'd1,
			8'd3, 8'd0, 8'd128, 8'd255};
		set_frame(4, 3, 1);
		foreach (pattern[k]) send_sample(pattern[k]);
	endtask

	// Shrink width and height inside a frame so both counters wrap, landing in a
	// single-row frame; then a plain single-row frame with two channels.
	task automatic test_mid_frame_wrap();
		set_frame(3, 4, 1);
		repeat (5) send_sample(random_sample());
		set_frame(2, 1, 1);
		send_sample('1);
		send_sample('0);
		send_frame(3, 1, 2);
	endtask

	task automatic test_random_frames();
		int first_sample;
		int frame_no;
		first_sample = samples_sent;
		frame_no = 0;
		while (samples_sent - first_sample < RANDOM_SAMPLES) begin
			frame_no++;
			if (frame_no == 1) begin
				send_frame(3, 3, 1);
			end else if (frame_no == 4) begin
				// long stretch with no idling on either side
				gap_pct   = 0;
				stall_pct = 0;
				send_frame(24, 6, 2);
				gap_pct   = IDLE_PCT;
				stall_pct = IDLE_PCT;
			end else begin
				send_frame($urandom_range(3, 12), $urandom_range(3, 8), $urandom_range(1, 4));
			end
		end
	endtask

	// Hold the output long enough that the block backs up into its input.
	task automatic test_backpressure();
		set_frame(16, 10, 2);
		hold_requests++;
		gap_pct = 0;
		repeat (16 * 10 * 2) send_sample(random_sample());
		gap_pct = IDLE_PCT;
		wait_idle();
	endtask

	// Start frames at the largest sizes; the next size change folds the first one away.
	task automatic test_largest_sizes();
		set_frame(2048, 4096, 4);
		repeat (LARGE_SAMPLES) send_sample(random_sample());
		set_frame(3, 4096, 1);
		repeat (LARGE_SAMPLES) send_sample(random_sample());
	endtask

	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		res_t due;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (sharpened_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$error("unexpected result beat: row %0d index %0d value %0d",
						dout_if.out_row, dout_if.out_index, dout_if.value);
			end else begin
				due = sharpened_due.pop_front();
				check_field("value", due.value, dout_if.value);
				check_field("out_row", due.row, dout_if.out_row);
				check_field("out_index", due.index, dout_if.out_index);
				check_field("frame_end", due.frame_end, dout_if.frame_end);
			end
		end
	end

	// Count cycles with no beat on either channel.
	always @(posedge clk) begin
		if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		din_if.valid  = 1'b0;
		din_if.sample = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_saturation();
		test_mid_frame_wrap();
		test_random_frames();
		test_backpressure();
		test_largest_sizes();
		wait_idle();
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sh3_pkg.sv
rtl/core/sh3_in_if.sv
rtl/core/sh3_out_if.sv
rtl/core/sh3_ram.sv
rtl/core/sh3_pos.sv
rtl/core/sh3_kern.sv
rtl/core/sharpen_3x3_stencil.sv
tb/sv/testbench.sv
